// File: hw/rtl/ljpf_pkg.sv
`default_nettype none
package ljpf_pkg;

	// Q16.16 positions
	localparam int POS_FRAC = 16;

	// fixed latencies of the shared arithmetic blocks
	localparam int DIV_LAT = 96;
	localparam int MUL_LAT = 3;

	localparam int CFG_IDX_W = 3;

	localparam logic [CFG_IDX_W-1:0] REG_BOX_X   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BOX_Y   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BOX_Z   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_EPSILON = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SIGMA   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_CUTOFF  = 3'd5;

	localparam logic [30:0] BOX_RESET    = 31'd655360;
	localparam logic [31:0] EPS_RESET    = 32'd174483;
	localparam logic [30:0] SIGMA_RESET  = 31'd223346;
	localparam logic [30:0] CUTOFF_RESET = 31'd558366;

	localparam logic [46:0] MAG_MAX = {47{1'b1}};

endpackage
`default_nettype wire

// File: hw/rtl/lj_pair_force.sv
`default_nettype none
// channel  | handshake          | payload
// config   | cfg_we             | cfg_idx, cfg_wdata
// pair in  | start (busy low)   | first_x/y/z, partner_x/y/z
// result   | done, one cycle    | force_x/y/z, pair_potential, within_cutoff
//
// one pair per cycle; a result passes through the 96-stage bit-per-stage
// divider and the chain of five 3-stage fixed point multipliers.
// busy stays low.
// arst_n sets the configuration registers to their reset values and clears the stage valid bits.
// results cannot be held off, so nothing in the pipe ever stalls.
module lj_pair_force (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [ljpf_pkg::CFG_IDX_W-1:0]    cfg_idx,
	input  logic [31:0]                       cfg_wdata,
	input  logic                              start,
	output logic                              busy,
	input  logic signed [31:0]                first_x,
	input  logic signed [31:0]                first_y,
	input  logic signed [31:0]                first_z,
	input  logic signed [31:0]                partner_x,
	input  logic signed [31:0]                partner_y,
	input  logic signed [31:0]                partner_z,
	output logic                              done,
	output logic signed [47:0]                force_x,
	output logic signed [47:0]                force_y,
	output logic signed [47:0]                force_z,
	output logic signed [47:0]                pair_potential,
	output logic                              within_cutoff
);

	localparam int T_OK     = 38;
	localparam int T_DIV    = T_OK + ljpf_pkg::DIV_LAT;
	localparam int T_MAG    = T_DIV + 4 * ljpf_pkg::MUL_LAT + 1;
	localparam int T_A24    = T_MAG + 1;
	localparam int T_F      = T_A24 + ljpf_pkg::MUL_LAT;
	localparam int LAT      = T_F + 1;
	localparam int U_DLY    = T_A24 - T_DIV;
	localparam int SIDE_DLY = T_F - T_OK;
	localparam int NEG_DLY  = T_F - T_MAG;
	localparam int POT_DLY  = T_F - T_A24;
	localparam int ML       = ljpf_pkg::MUL_LAT;

	typedef struct packed {
		logic       ok;
		logic [2:0] rneg;
		logic [2:0] rzero;
	} side_t;

	// configuration
	logic [30:0] box_q [0:2];
	logic [31:0] eps_q;
	logic [30:0] sigma_q;
	logic [30:0] cutoff_q;
	logic [63:0] sig2_q;
	logic [63:0] rc2_q;
	logic [63:0] epsq;

	logic            accept;
	logic [LAT-1:0]  vld_q;

	logic signed [31:0] fpos [0:2];
	logic signed [31:0] ppos [0:2];

	logic signed [32:0] d_s1 [0:2];
	logic [31:0]        a_s1 [0:2];
	logic signed [32:0] md_s [0:2][1:32];
	logic [31:0]        ma_s [0:2][1:32];
	logic [30:0]        mrem_s [0:2][1:32];

	logic signed [32:0] r_fix [0:2];
	logic signed [32:0] r_s34 [0:2];
	logic [31:0]        ar_s35 [0:2];
	logic [2:0]         rneg_s35;
	logic [63:0]        sq_s36 [0:2];
	logic [31:0]        ar_s36 [0:2];
	logic [2:0]         rneg_s36;
	logic [63:0]        d2_s37;
	logic [31:0]        ar_s37 [0:2];
	logic [2:0]         rneg_s37;
	logic [63:0]        d2_s38;
	logic [31:0]        ar_s38 [0:2];
	side_t              side_s38;
	side_t              side_dly [0:SIDE_DLY-1];

	logic [63:0] s2_div;
	logic [63:0] c2_div;
	logic [63:0] u_div [0:2];
	logic [63:0] u_dly [0:2][0:U_DLY-1];

	logic [63:0] m1, s6, s12, e12, e6;
	logic [63:0] cm1, c6, c12, ce12, ce6;
	logic [63:0] s2_dly [0:ML-1];
	logic [63:0] s6_dly [0:ML-1];
	logic [63:0] c2_dly [0:ML-1];
	logic [63:0] c6_dly [0:ML-1];

	logic [63:0] two;
	logic [63:0] mag;
	logic        neg;
	logic [63:0] mag_s147;
	logic        neg_s147;
	logic [NEG_DLY-1:0] neg_dly;
	logic [55:0] t12_s147, t6_s147, tc12_s147, tc6_s147;
	logic [68:0] mag24;
	logic [63:0] a24_s148;
	logic signed [58:0] pot_raw;
	logic signed [47:0] pot_sat;
	logic signed [47:0] pot_s148;
	logic signed [47:0] pot_dly [0:POT_DLY-1];
	logic [63:0] fp [0:2];
	logic signed [47:0] fout [0:2];

	assign busy   = 1'b0;
	assign accept = start & ~busy;
	assign epsq   = {24'b0, eps_q, 8'b0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_q[0] <= ljpf_pkg::BOX_RESET;
			box_q[1] <= ljpf_pkg::BOX_RESET;
			box_q[2] <= ljpf_pkg::BOX_RESET;
			eps_q    <= ljpf_pkg::EPS_RESET;
			sigma_q  <= ljpf_pkg::SIGMA_RESET;
			cutoff_q <= ljpf_pkg::CUTOFF_RESET;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				ljpf_pkg::REG_BOX_X:   box_q[0] <= cfg_wdata[30:0];
				ljpf_pkg::REG_BOX_Y:   box_q[1] <= cfg_wdata[30:0];
				ljpf_pkg::REG_BOX_Z:   box_q[2] <= cfg_wdata[30:0];
				ljpf_pkg::REG_EPSILON: eps_q    <= cfg_wdata;
				ljpf_pkg::REG_SIGMA:   sigma_q  <= cfg_wdata[30:0];
				ljpf_pkg::REG_CUTOFF:  cutoff_q <= cfg_wdata[30:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		sig2_q <= 64'(sigma_q) * 64'(sigma_q);
		rc2_q  <= 64'(cutoff_q) * 64'(cutoff_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[LAT-2:0], accept};
		end
	end

	assign fpos[0] = first_x;
	assign fpos[1] = first_y;
	assign fpos[2] = first_z;
	assign ppos[0] = partner_x;
	assign ppos[1] = partner_y;
	assign ppos[2] = partner_z;

	// displacement and its magnitude
	always_ff @(posedge clk) begin
		for (int ax = 0; ax < 3; ax++) begin
			d_s1[ax] <= {ppos[ax][31], ppos[ax]} - {fpos[ax][31], fpos[ax]};
			a_s1[ax] <= ppos[ax][31] ^ fpos[ax][31] ?
				(ppos[ax] >= fpos[ax] ?
					32'(ppos[ax] - fpos[ax]) : 32'(fpos[ax] - ppos[ax])) :
				(ppos[ax] >= fpos[ax] ?
					32'(ppos[ax] - fpos[ax]) : 32'(fpos[ax] - ppos[ax]));
		end
	end

	// |d| mod box, one bit per stage
	for (genvar ax = 0; ax < 3; ax++) begin : g_axis
		for (genvar j = 0; j < 32; j++) begin : g_mod
			logic signed [32:0] src_d;
			logic [31:0]        src_a;
			logic [30:0]        src_rem;
			logic [31:0]        trial;
			logic [31:0]        diff;
			logic               ge;

			if (j == 0) begin : g_first
				assign src_d   = d_s1[ax];
				assign src_a   = a_s1[ax];
				assign src_rem = '0;
			end else begin : g_next
				assign src_d   = md_s[ax][j];
				assign src_a   = ma_s[ax][j];
				assign src_rem = mrem_s[ax][j];
			end

			assign trial = {src_rem, src_a[31-j]};
			assign diff  = trial - {1'b0, box_q[ax]};
			assign ge    = trial >= {1'b0, box_q[ax]};

			always_ff @(posedge clk) begin
				md_s[ax][j+1]   <= src_d;
				ma_s[ax][j+1]   <= src_a;
				mrem_s[ax][j+1] <= ge ? diff[30:0] : trial[30:0];
			end
		end
	end

	// minimum image: result in (-L/2, L/2], no wrap when L is zero
	always_comb begin
		logic [30:0] rem;
		logic [30:0] m;
		logic        dneg;
		for (int ax = 0; ax < 3; ax++) begin
			rem  = mrem_s[ax][32];
			dneg = md_s[ax][32][32];
			m    = (dneg && rem != '0) ? box_q[ax] - rem : rem;
			if (box_q[ax] == '0) begin
				r_fix[ax] = md_s[ax][32];
			end else if ({m, 1'b0} > {1'b0, box_q[ax]}) begin
				r_fix[ax] = {2'b0, m} - {2'b0, box_q[ax]};
			end else begin
				r_fix[ax] = {2'b0, m};
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int ax = 0; ax < 3; ax++) begin
			r_s34[ax]    <= r_fix[ax];
			ar_s35[ax]   <= r_s34[ax][32] ? 32'(-r_s34[ax]) : r_s34[ax][31:0];
			rneg_s35[ax] <= r_s34[ax][32];
			sq_s36[ax]   <= 64'(ar_s35[ax]) * 64'(ar_s35[ax]);
			ar_s36[ax]   <= ar_s35[ax];
			rneg_s36[ax] <= rneg_s35[ax];
			ar_s37[ax]   <= ar_s36[ax];
			rneg_s37[ax] <= rneg_s36[ax];
			ar_s38[ax]   <= ar_s37[ax];
			side_s38.rneg[ax]  <= rneg_s37[ax];
			side_s38.rzero[ax] <= ar_s37[ax] == '0;
		end
		d2_s37      <= sq_s36[0] + sq_s36[1] + sq_s36[2];
		d2_s38      <= d2_s37;
		side_s38.ok <= d2_s37 != '0 && d2_s37 <= rc2_q;
	end

	always_ff @(posedge clk) begin
		side_dly[0] <= side_s38;
		for (int k = 1; k < SIDE_DLY; k++) begin
			side_dly[k] <= side_dly[k-1];
		end
	end

	ljpf_div u_div_s2 (.clk(clk), .num(sig2_q), .den(d2_s38), .quo(s2_div));
	ljpf_div u_div_c2 (.clk(clk), .num(sig2_q), .den(rc2_q), .quo(c2_div));

	for (genvar ax = 0; ax < 3; ax++) begin : g_udiv
		ljpf_div u_div_u (
			.clk(clk),
			.num(64'(ar_s38[ax]) << ljpf_pkg::POS_FRAC),
			.den(d2_s38),
			.quo(u_div[ax])
		);
	end

	always_ff @(posedge clk) begin
		for (int ax = 0; ax < 3; ax++) begin
			u_dly[ax][0] <= u_div[ax];
			for (int k = 1; k < U_DLY; k++) begin
				u_dly[ax][k] <= u_dly[ax][k-1];
			end
		end
		s2_dly[0] <= s2_div;
		s6_dly[0] <= s6;
		c2_dly[0] <= c2_div;
		c6_dly[0] <= c6;
		for (int k = 1; k < ML; k++) begin
			s2_dly[k] <= s2_dly[k-1];
			s6_dly[k] <= s6_dly[k-1];
			c2_dly[k] <= c2_dly[k-1];
			c6_dly[k] <= c6_dly[k-1];
		end
	end

	// sigma/r powers and the same for the cutoff shift
	ljpf_mul u_m1  (.clk(clk), .a(s2_div), .b(s2_div), .p(m1));
	ljpf_mul u_s6  (.clk(clk), .a(m1), .b(s2_dly[ML-1]), .p(s6));
	ljpf_mul u_s12 (.clk(clk), .a(s6), .b(s6), .p(s12));
	ljpf_mul u_e12 (.clk(clk), .a(s12), .b(epsq), .p(e12));
	ljpf_mul u_e6  (.clk(clk), .a(s6_dly[ML-1]), .b(epsq), .p(e6));
	ljpf_mul u_cm1 (.clk(clk), .a(c2_div), .b(c2_div), .p(cm1));
	ljpf_mul u_c6  (.clk(clk), .a(cm1), .b(c2_dly[ML-1]), .p(c6));
	ljpf_mul u_c12 (.clk(clk), .a(c6), .b(c6), .p(c12));
	ljpf_mul u_ce12 (.clk(clk), .a(c12), .b(epsq), .p(ce12));
	ljpf_mul u_ce6 (.clk(clk), .a(c6_dly[ML-1]), .b(epsq), .p(ce6));

	assign two = e12[63] ? {64{1'b1}} : {e12[62:0], 1'b0};
	assign neg = two < e6;
	assign mag = neg ? e6 - two : two - e6;

	function automatic logic [55:0] pot_term(input logic [63:0] x);
		// saturated 4*x, then Q32.32 down to Q32.24
		return (|x[63:62]) ? {56{1'b1}} : x[61:6];
	endfunction

	always_ff @(posedge clk) begin
		mag_s147  <= mag;
		neg_s147  <= neg;
		t12_s147  <= pot_term(e12);
		t6_s147   <= pot_term(e6);
		tc12_s147 <= pot_term(ce12);
		tc6_s147  <= pot_term(ce6);
	end

	assign mag24   = ({5'b0, mag_s147} << 4) + ({5'b0, mag_s147} << 3);
	assign pot_raw = ($signed({3'b0, t12_s147}) - $signed({3'b0, t6_s147}))
		- ($signed({3'b0, tc12_s147}) - $signed({3'b0, tc6_s147}));

	always_comb begin
		if (pot_raw > $signed(59'({1'b0, ljpf_pkg::MAG_MAX}))) begin
			pot_sat = {1'b0, ljpf_pkg::MAG_MAX};
		end else if (pot_raw < -$signed(59'({1'b0, ljpf_pkg::MAG_MAX})) - 59'sd1) begin
			pot_sat = {1'b1, 47'b0};
		end else begin
			pot_sat = pot_raw[47:0];
		end
	end

	always_ff @(posedge clk) begin
		a24_s148   <= (|mag24[68:64]) ? {64{1'b1}} : mag24[63:0];
		pot_s148   <= pot_sat;
		pot_dly[0] <= pot_s148;
		for (int k = 1; k < POT_DLY; k++) begin
			pot_dly[k] <= pot_dly[k-1];
		end
		neg_dly <= {neg_dly[NEG_DLY-2:0], neg_s147};
	end

	for (genvar ax = 0; ax < 3; ax++) begin : g_force
		logic [55:0] f56;
		logic [46:0] fc;

		ljpf_mul u_mf (.clk(clk), .a(a24_s148), .b(u_dly[ax][U_DLY-1]), .p(fp[ax]));

		assign f56 = fp[ax][63:8];
		assign fc  = (|f56[55:47]) ? ljpf_pkg::MAG_MAX : f56[46:0];

		// force on atom i points against r when the bracket is repulsive
		always_comb begin
			if (!side_dly[SIDE_DLY-1].ok || side_dly[SIDE_DLY-1].rzero[ax]) begin
				fout[ax] = '0;
			end else if (neg_dly[NEG_DLY-1] == side_dly[SIDE_DLY-1].rneg[ax]) begin
				fout[ax] = -$signed({1'b0, fc});
			end else begin
				fout[ax] = $signed({1'b0, fc});
			end
		end
	end

	always_ff @(posedge clk) begin
		force_x        <= fout[0];
		force_y        <= fout[1];
		force_z        <= fout[2];
		pair_potential <= side_dly[SIDE_DLY-1].ok ? pot_dly[POT_DLY-1] : '0;
		within_cutoff  <= side_dly[SIDE_DLY-1].ok;
	end

	assign done = vld_q[LAT-1];

endmodule
`default_nettype wire

// File: hw/rtl/ljpf_div.sv
`default_nettype none
// quo = min(floor(num * 2^32 / den), 2^64 - 1), one quotient bit per stage
module ljpf_div (
	input  logic        clk,
	input  logic [63:0] num,
	input  logic [63:0] den,
	output logic [63:0] quo
);

	localparam int NSTG = ljpf_pkg::DIV_LAT;

	logic [63:0] num_s [1:NSTG];
	logic [63:0] den_s [1:NSTG];
	logic [63:0] rem_s [1:NSTG];
	logic [63:0] quo_s [1:NSTG];
	logic        ovf_s [1:NSTG];

	for (genvar i = 0; i < NSTG; i++) begin : g_row
		logic [63:0] src_num;
		logic [63:0] src_den;
		logic [63:0] src_rem;
		logic [63:0] src_quo;
		logic        src_ovf;
		logic        nbit;
		logic [64:0] trial;
		logic [64:0] diff;
		logic        ge;

		if (i == 0) begin : g_first
			assign src_num = num;
			assign src_den = den;
			assign src_rem = '0;
			assign src_quo = '0;
			assign src_ovf = 1'b0;
		end else begin : g_next
			assign src_num = num_s[i];
			assign src_den = den_s[i];
			assign src_rem = rem_s[i];
			assign src_quo = quo_s[i];
			assign src_ovf = ovf_s[i];
		end

		// numerator is num followed by 32 zero bits
		if (i < 64) begin : g_nbit
			assign nbit = src_num[63-i];
		end else begin : g_zbit
			assign nbit = 1'b0;
		end

		assign trial = {src_rem, nbit};
		assign diff  = trial - {1'b0, src_den};
		assign ge    = trial >= {1'b0, src_den};

		always_ff @(posedge clk) begin
			num_s[i+1] <= src_num;
			den_s[i+1] <= src_den;
			rem_s[i+1] <= ge ? diff[63:0] : trial[63:0];
			if (i < 32) begin
				// any quotient bit above 2^63 means overflow
				ovf_s[i+1] <= src_ovf | ge;
				quo_s[i+1] <= src_quo;
			end else begin
				ovf_s[i+1] <= src_ovf;
				quo_s[i+1] <= {src_quo[62:0], ge};
			end
		end
	end

	assign quo = ovf_s[NSTG] ? {64{1'b1}} : quo_s[NSTG];

endmodule
`default_nettype wire

// File: hw/rtl/ljpf_mul.sv
`default_nettype none
// p = min(floor(a * b / 2^32), 2^64 - 1), three stages
module ljpf_mul (
	input  logic        clk,
	input  logic [63:0] a,
	input  logic [63:0] b,
	output logic [63:0] p
);

	logic [63:0] hh_s1;
	logic [63:0] hl_s1;
	logic [63:0] lh_s1;
	logic [63:0] ll_s1;
	logic [63:0] hh_s2;
	logic [64:0] mid_s2;
	logic [31:0] llh_s2;
	logic [96:0] sum;
	logic [63:0] p_s3;

	assign sum = {1'b0, hh_s2, 32'b0} + {32'b0, mid_s2} + {65'b0, llh_s2};

	always_ff @(posedge clk) begin
		hh_s1  <= 64'(a[63:32]) * 64'(b[63:32]);
		hl_s1  <= 64'(a[63:32]) * 64'(b[31:0]);
		lh_s1  <= 64'(a[31:0]) * 64'(b[63:32]);
		ll_s1  <= 64'(a[31:0]) * 64'(b[31:0]);
		hh_s2  <= hh_s1;
		mid_s2 <= {1'b0, hl_s1} + {1'b0, lh_s1};
		llh_s2 <= ll_s1[63:32];
		p_s3   <= (|sum[96:64]) ? {64{1'b1}} : sum[63:0];
	end

	assign p = p_s3;

endmodule
`default_nettype wire

// File: bench/lj_pair_force_tb.sv
`default_nettype none
module lj_pair_force_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int PIPE_LAT = 152;
	localparam int STALL_LIMIT = 2000;
	localparam logic [63:0] ALL1 = 64'hFFFF_FFFF_FFFF_FFFF;
	// index past the last register, writes to it are dropped
	localparam logic [ljpf_pkg::CFG_IDX_W-1:0] REG_NONE = 3'd6;

	typedef struct packed {
		logic signed [31:0] ix, iy, iz, jx, jy, jz;
	} pair_t;

	typedef struct packed {
		logic signed [47:0] fx, fy, fz, pot;
		logic               hit;
	} force_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [ljpf_pkg::CFG_IDX_W-1:0] cfg_idx = '0;
	logic [31:0] cfg_wdata = '0;
	logic start = 1'b0;
	logic busy;
	logic signed [31:0] first_x = '0, first_y = '0, first_z = '0;
	logic signed [31:0] partner_x = '0, partner_y = '0, partner_z = '0;
	logic done;
	logic signed [47:0] force_x, force_y, force_z, pair_potential;
	logic within_cutoff;

	lj_pair_force dut (.*);

	always #6 clk = ~clk;

	// local copy of the registers
	logic [63:0] box_l [3];
	logic [63:0] eps_r, sig_r, cut_r;

	pair_t  pending_pairs[$];
	force_t expected_forces[$];
	int errors = 0;
	int accepted = 0, received = 0, hits = 0;
	bit idle_enable = 1'b1;
	int gap_left = 0;
	int stall_cycles = 0;

	function automatic logic [63:0] sadd(logic [63:0] a, logic [63:0] b);
		logic [64:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[64] ? ALL1 : s[63:0];
	endfunction

	function automatic logic [63:0] qmul(logic [63:0] a, logic [63:0] b);
		logic [127:0] p;
		p = {64'd0, a} * {64'd0, b};
		return (p[127:96] != 0) ? ALL1 : p[95:32];
	endfunction

	function automatic logic [63:0] qdiv(logic [63:0] num, logic [63:0] den);
		logic [127:0] q;
		q = {num, 32'd0} / {64'd0, den};
		return (q[127:64] != 0) ? ALL1 : q[63:0];
	endfunction

	function automatic logic [63:0] smul(logic [63:0] a, int k);
		logic [127:0] p;
		p = {64'd0, a} * k;
		return (p[127:64] != 0) ? ALL1 : p[63:0];
	endfunction

	function automatic longint min_image(longint d, logic [63:0] len);
		longint l, r;
		if (len == 0) return d;
		l = longint'(len);
		r = d % l;
		if (r < 0) r += l;
		if (2 * r > l) r -= l;
		return r;
	endfunction

	function automatic force_t lj_force(pair_t p);
		force_t o;
		longint r[3];
		logic [63:0] ar, d2, rc2, sig2, epsq, s2, s6, s12, e12, e6, two, mag, a24;
		logic [63:0] u, f, c2, c6, c12;
		longint fv, pot;
		bit neg;
		o = '0;
		r[0] = min_image(longint'(p.jx) - longint'(p.ix), box_l[0]);
		r[1] = min_image(longint'(p.jy) - longint'(p.iy), box_l[1]);
		r[2] = min_image(longint'(p.jz) - longint'(p.iz), box_l[2]);
		d2 = 0;
		for (int k = 0; k < 3; k++) d2 += r[k] * r[k];
		rc2 = cut_r * cut_r;
		if (d2 == 0 || d2 > rc2) return o;
		sig2 = sig_r * sig_r;
		epsq = eps_r << 8;
		s2 = qdiv(sig2, d2);
		s6 = qmul(qmul(s2, s2), s2);
		s12 = qmul(s6, s6);
		e12 = qmul(s12, epsq);
		e6 = qmul(s6, epsq);
		two = sadd(e12, e12);
		neg = two < e6;
		mag = neg ? e6 - two : two - e6;
		a24 = smul(mag, 24);
		for (int k = 0; k < 3; k++) begin
			ar = (r[k] < 0) ? -r[k] : r[k];
			u = qdiv(ar << ljpf_pkg::POS_FRAC, d2);
			f = qmul(a24, u) >> 8;
			if (f > {17'd0, ljpf_pkg::MAG_MAX}) f = {17'd0, ljpf_pkg::MAG_MAX};
			fv = longint'(f);
			if (neg == (r[k] < 0)) fv = -fv;
			if (ar == 0) fv = 0;
			if (k == 0) o.fx = fv[47:0];
			else if (k == 1) o.fy = fv[47:0];
			else o.fz = fv[47:0];
		end
		c2 = qdiv(sig2, rc2);
		c6 = qmul(qmul(c2, c2), c2);
		c12 = qmul(c6, c6);
		pot = (longint'(smul(e12, 4) >> 8) - longint'(smul(e6, 4) >> 8))
			- (longint'(smul(qmul(c12, epsq), 4) >> 8)
			- longint'(smul(qmul(c6, epsq), 4) >> 8));
		if (pot > 64'sh7FFF_FFFF_FFFF) pot = 64'sh7FFF_FFFF_FFFF;
		if (pot < -64'sh8000_0000_0000) pot = -64'sh8000_0000_0000;
		o.pot = pot[47:0];
		o.hit = 1'b1;
		return o;
	endfunction

	// driver
	always @(posedge clk) begin
		if (start && !busy) begin
			expected_forces.push_back(lj_force(pending_pairs.pop_front()));
			accepted++;
		end
		if (gap_left > 0) begin
			gap_left--;
			start <= 1'b0;
		end else if (idle_enable && $urandom_range(0, 15) == 0) begin
			gap_left = $urandom_range(0, 10);
			start <= 1'b0;
		end else if (pending_pairs.size() > 0) begin
			start <= 1'b1;
			{first_x, first_y, first_z, partner_x, partner_y, partner_z} <= pending_pairs[0];
		end else
			start <= 1'b0;
	end

	// monitor
	always @(posedge clk) begin
		force_t want;
		if (done) begin
			received++;
			if (expected_forces.size() == 0) begin
				errors++;
				$display("%0t: result with no pair outstanding", $time);
			end else begin
				want = expected_forces.pop_front();
				hits += within_cutoff;
				if (force_x !== want.fx) begin
					errors++;
					$display("%0t: force_x exp %0d got %0d", $time, want.fx, force_x);
				end
				if (force_y !== want.fy) begin
					errors++;
					$display("%0t: force_y exp %0d got %0d", $time, want.fy, force_y);
				end
				if (force_z !== want.fz) begin
					errors++;
					$display("%0t: force_z exp %0d got %0d", $time, want.fz, force_z);
				end
				if (pair_potential !== want.pot) begin
					errors++;
					$display("%0t: pair_potential exp %0d got %0d", $time, want.pot,
						pair_potential);
				end
				if (within_cutoff !== want.hit) begin
					errors++;
					$display("%0t: within_cutoff exp %0d got %0d", $time, want.hit,
						within_cutoff);
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if ((start && !busy) || done || !arst_n) stall_cycles = 0;
		else stall_cycles++;
		if (stall_cycles > STALL_LIMIT) begin
			$display("lj_pair_force_tb failed");
			$finish;
		end
	end

	task automatic write_reg(logic [ljpf_pkg::CFG_IDX_W-1:0] idx, logic [31:0] v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			ljpf_pkg::REG_BOX_X: box_l[0] = 64'(v & 32'h7FFF_FFFF);
			ljpf_pkg::REG_BOX_Y: box_l[1] = 64'(v & 32'h7FFF_FFFF);
			ljpf_pkg::REG_BOX_Z: box_l[2] = 64'(v & 32'h7FFF_FFFF);
			ljpf_pkg::REG_EPSILON: eps_r = 64'(v);
			ljpf_pkg::REG_SIGMA: sig_r = 64'(v & 32'h7FFF_FFFF);
			ljpf_pkg::REG_CUTOFF: cut_r = 64'(v & 32'h7FFF_FFFF);
			default: ;
		endcase
	endtask

	task automatic drain();
		while (pending_pairs.size() > 0 || expected_forces.size() > 0 || start)
			@(posedge clk);
		repeat (PIPE_LAT + 10) @(posedge clk);
	endtask

	function automatic logic signed [31:0] near(logic signed [31:0] base, int span);
		return base + $signed($urandom_range(0, 2 * span)) - span;
	endfunction

	task automatic add_pair(logic signed [31:0] ix, iy, iz, jx, jy, jz);
		pair_t p;
		p = {ix, iy, iz, jx, jy, jz};
		pending_pairs.push_back(p);
	endtask

	task automatic add_random(int n, int span);
		logic signed [31:0] ix, iy, iz;
		for (int i = 0; i < n; i++) begin
			ix = $urandom; iy = $urandom; iz = $urandom;
			if ($urandom_range(0, 9) == 0)
				add_pair(ix, iy, iz, $urandom, $urandom, $urandom);
			else
				add_pair(ix, iy, iz, near(ix, span), near(iy, span), near(iz, span));
		end
	endtask

	initial begin
		box_l[0] = 64'(ljpf_pkg::BOX_RESET);
		box_l[1] = 64'(ljpf_pkg::BOX_RESET);
		box_l[2] = 64'(ljpf_pkg::BOX_RESET);
		eps_r = 64'(ljpf_pkg::EPS_RESET);
		sig_r = 64'(ljpf_pkg::SIGMA_RESET);
		cut_r = 64'(ljpf_pkg::CUTOFF_RESET);
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed pairs at reset settings
		add_pair(0, 0, 0, 0, 0, 0);
		add_pair(0, 0, 0, 32'sd250000, 0, 0);
		add_pair(0, 0, 0, 0, -32'sd250000, 0);
		add_pair(0, 0, 0, 32'sd327680, 0, 0);
		add_pair(32'sd327680, 0, 0, 0, 0, 0);
		add_pair(0, 0, 0, 32'sd558366, 0, 0);
		add_pair(0, 0, 0, 32'sd558367, 0, 0);
		add_pair(0, 0, 0, 1, 0, 0);
		add_pair(0, 0, 0, 1, 1, 1);
		add_pair(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		add_pair(32'h8000_0000, 0, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 0, 32'hFFFF_FFFF);
		add_pair(32'sd100000, 32'sd100000, 32'sd100000, 32'sd200000, 32'sd50000, 32'sd300000);
		drain();

		// pause until everything has come back, then narrow-range random
		add_random(300, 400000);
		drain();

		// zero box on one axis, big epsilon, small sigma
		write_reg(ljpf_pkg::REG_BOX_X, 0);
		write_reg(ljpf_pkg::REG_EPSILON, 32'hFFFF_FFFF);
		write_reg(ljpf_pkg::REG_SIGMA, 32'd65536);
		write_reg(ljpf_pkg::REG_CUTOFF, 32'd300000);
		write_reg(REG_NONE, 32'h1234);
		add_pair(0, 0, 0, 32'sd100, 0, 0);
		add_pair(0, 0, 0, 32'sd327680, 0, 0);
		add_random(300, 300000);
		drain();

		// extremes: largest boxes on x and y, zero sigma and epsilon
		write_reg(ljpf_pkg::REG_BOX_X, 32'h7FFF_FFFF);
		write_reg(ljpf_pkg::REG_BOX_Y, 32'h7FFF_FFFF);
		write_reg(ljpf_pkg::REG_BOX_Z, 32'd65536);
		write_reg(ljpf_pkg::REG_SIGMA, 0);
		write_reg(ljpf_pkg::REG_EPSILON, 0);
		write_reg(ljpf_pkg::REG_CUTOFF, 32'h7FFF_FFFF);
		add_pair(0, 0, 0, 32'sd32768, 0, 32'sd32768);
		add_random(300, 2000000);
		drain();

		// huge sigma, small cutoff and small boxes on y and z
		write_reg(ljpf_pkg::REG_SIGMA, 32'h7FFF_FFFF);
		write_reg(ljpf_pkg::REG_EPSILON, 32'h0100_0000);
		write_reg(ljpf_pkg::REG_CUTOFF, 32'd65536);
		write_reg(ljpf_pkg::REG_BOX_Z, 32'd131072);
		write_reg(ljpf_pkg::REG_BOX_Y, 32'd99999);
		add_pair(0, 0, 0, 0, 32'sd49999, 32'sd65536);
		add_random(300, 60000);
		drain();

		// moderate random settings
		for (int ph = 0; ph < 3; ph++) begin
			write_reg(ljpf_pkg::REG_BOX_X, $urandom_range(65536, 2000000));
			write_reg(ljpf_pkg::REG_BOX_Y, $urandom_range(65536, 2000000));
			write_reg(ljpf_pkg::REG_BOX_Z, $urandom_range(65536, 2000000));
			write_reg(ljpf_pkg::REG_EPSILON, $urandom);
			write_reg(ljpf_pkg::REG_SIGMA, $urandom_range(0, 400000));
			write_reg(ljpf_pkg::REG_CUTOFF, $urandom_range(65536, 1000000));
			if (ph == 2) idle_enable = 1'b0;
			add_random(230, 700000);
			drain();
		end

		$display("covered %0d pairs, %0d results, %0d inside cutoff, across seven settings",
			accepted, received, hits);
		if (errors == 0 && expected_forces.size() == 0)
			$display("lj_pair_force_tb passed");
		else
			$display("lj_pair_force_tb failed");
		$finish;
	end
endmodule
`default_nettype wire
